FILE: hw/rtl/height_grid_bilinear_sampler_macros.svh
// assertion macros shared by the height grid sampler modules
// no dependencies; included by the files that carry concurrent assertions
`ifndef HEIGHT_GRID_BILINEAR_SAMPLER_MACROS_SVH
`define HEIGHT_GRID_BILINEAR_SAMPLER_MACROS_SVH

// same-cycle implication
`define HGBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HGBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/hgbs_pkg.sv
// types and constants for the height grid bilinear sampler
// no dependencies; used by the datapath, controller and top level
`default_nettype none

package hgbs_pkg;

   localparam int HEIGHT_W  = 16;
   localparam int COORD_W   = 16;
   localparam int IDX_W     = 17;  // linear cell index incl. neighbor offsets
   localparam int CSR_IDX_W = 8;

   // operation codes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAP_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_HEIGHT = 8'd1;

   localparam logic [7:0] MAP_DIM_RESET = 8'd62;
   localparam logic [7:0] MAP_DIM_MAX   = 8'd254;

   // neighbor select for the grid memory address
   localparam logic [1:0] SEL_P0 = 2'd0;
   localparam logic [1:0] SEL_P1 = 2'd1;
   localparam logic [1:0] SEL_P2 = 2'd2;
   localparam logic [1:0] SEL_P3 = 2'd3;

   typedef struct packed {
      logic [1:0]                 operation;
      logic [COORD_W-1:0]         x_coord;
      logic [COORD_W-1:0]         y_coord;
      logic signed [HEIGHT_W-1:0] write_height;
   } req_type;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] sample_height;
      logic                       out_of_range;
      logic [7:0]                 dirty_min_x;
      logic [7:0]                 dirty_min_y;
      logic [7:0]                 dirty_max_x;
      logic [7:0]                 dirty_max_y;
      logic [15:0]                change_count;
   } rsp_type;

   typedef struct packed {
      logic       clear_wr;
      logic       capture;
      logic       calc_index;
      logic [1:0] rd_sel;
      logic       mac_first;
      logic       mac_second;
      logic       sum_first;
      logic       sum_second;
      logic       finish;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_sample;
   } dp_sts_type;

endpackage

`default_nettype wire

FILE: hw/rtl/hgbs_datapath.sv
// grid memory, index and range logic, blend multiply-accumulate, dirty box and result register
// depends on hgbs_pkg; driven by hgbs_controller commands
`default_nettype none

module hgbs_datapath #(
   parameter int MAX_SIDE  = 256,
   parameter int FRAC_BITS = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire hgbs_pkg::dp_cmd_type        cmd,
   output hgbs_pkg::dp_sts_type             sts,
   input  wire hgbs_pkg::req_type           req_payload,
   output hgbs_pkg::rsp_type                rsp_payload,
   input  wire                              csr_we,
   input  wire [hgbs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [7:0]                        csr_wdata
);

   localparam int unsigned CELLS = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int IDX_W  = hgbs_pkg::IDX_W;
   localparam int HW     = hgbs_pkg::HEIGHT_W;
   localparam int WT_W   = FRAC_BITS + 1;
   localparam int ROW_W  = HW + WT_W + 1;
   localparam int TOT_W  = ROW_W + WT_W + 1;
   localparam logic [WT_W-1:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [TOT_W-1:0] ROUND_BIAS =
      {{(TOT_W - 2*FRAC_BITS){1'b0}}, {(2*FRAC_BITS){1'b1}}};

   hgbs_pkg::req_type req_ff;
   hgbs_pkg::rsp_type rsp_ff;
   logic [7:0]        width_ff, height_ff;
   logic [IDX_W-1:0]  base_ff, base_in;
   logic              coord_ok_ff, coord_ok_in;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [HW-1:0]     grid_mem [0:CELLS-1];
   logic [HW-1:0]     rdata_ff;
   logic signed [ROW_W-1:0] row_ff, row_in, prod1;
   logic signed [TOT_W-1:0] total_ff, total_in, prod2, rnd, h_sh;
   logic [7:0]        min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic [7:0]        min_x_in, min_y_in, max_x_in, max_y_in;
   logic [15:0]       count_ff, count_in;

   logic [8:0]        cols, rows;
   logic [IDX_W-1:0]  cols_w, rows_w, ix_full, iy_full, offset, rd_idx, last_idx;
   logic              is_sample, is_write, is_clear, cell_ok, range_ok, write_ok;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic [HW-1:0]     mem_wdata;
   logic [WT_W-1:0]   wx0, wy0, mul_wx, mul_wy;
   logic [7:0]        ix8, iy8, csr_val;
   logic signed [HW-1:0] sample_h;

   assign cols    = {1'b0, width_ff} + 9'd2;
   assign rows    = {1'b0, height_ff} + 9'd2;
   assign cols_w  = IDX_W'(cols);
   assign rows_w  = IDX_W'(rows);
   assign ix_full = {1'b0, req_ff.x_coord} >> FRAC_BITS;
   assign iy_full = {1'b0, req_ff.y_coord} >> FRAC_BITS;
   assign ix8     = ix_full[7:0];
   assign iy8     = iy_full[7:0];

   assign is_sample = (req_ff.operation == hgbs_pkg::OP_SAMPLE);
   assign is_write  = (req_ff.operation == hgbs_pkg::OP_WRITE);
   assign is_clear  = (req_ff.operation == hgbs_pkg::OP_CLEAR);

   // sample needs the far corner cell inside the grid as well
   always_comb begin
      if (is_sample) begin
         coord_ok_in = (ix_full + IDX_W'(1) < cols_w) && (iy_full + IDX_W'(1) < rows_w);
      end else begin
         coord_ok_in = (ix_full < cols_w) && (iy_full < rows_w);
      end
   end

   assign base_in  = ({9'b0, iy8} * {8'b0, cols}) + IDX_W'(ix8);
   assign last_idx = base_ff + (is_sample ? (cols_w + IDX_W'(1)) : '0);
   assign cell_ok  = (32'(last_idx) < CELLS);
   assign range_ok = coord_ok_ff && cell_ok;
   assign write_ok = is_write && range_ok;

   always_comb begin
      case (cmd.rd_sel)
         hgbs_pkg::SEL_P0: offset = '0;
         hgbs_pkg::SEL_P1: offset = IDX_W'(1);
         hgbs_pkg::SEL_P2: offset = cols_w;
         hgbs_pkg::SEL_P3: offset = cols_w + IDX_W'(1);
         default:          offset = '0;
      endcase
   end

   assign rd_idx    = base_ff + offset;
   assign mem_addr  = cmd.clear_wr ? clr_cnt_ff : ADDR_W'(rd_idx);
   assign mem_we    = cmd.clear_wr || (cmd.finish && write_ok);
   assign mem_wdata = cmd.clear_wr ? '0 : req_ff.write_height;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= grid_mem[mem_addr];
   end

   // bilinear weights
   assign wx0    = ONE_FIX - {1'b0, req_ff.x_coord[FRAC_BITS-1:0]};
   assign wy0    = ONE_FIX - {1'b0, req_ff.y_coord[FRAC_BITS-1:0]};
   assign mul_wx = cmd.mac_first ? wx0 : {1'b0, req_ff.x_coord[FRAC_BITS-1:0]};
   assign mul_wy = cmd.sum_first ? wy0 : {1'b0, req_ff.y_coord[FRAC_BITS-1:0]};

   assign prod1 = ROW_W'($signed(rdata_ff)) * ROW_W'($signed({1'b0, mul_wx}));
   assign prod2 = TOT_W'(row_ff) * TOT_W'($signed({1'b0, mul_wy}));

   always_comb begin
      row_in = row_ff;
      if (cmd.mac_first) begin
         row_in = prod1;
      end else if (cmd.mac_second) begin
         row_in = row_ff + prod1;
      end
      total_in = total_ff;
      if (cmd.sum_first) begin
         total_in = prod2;
      end else if (cmd.sum_second) begin
         total_in = total_ff + prod2;
      end
   end

   // divide by one squared, truncating toward zero
   assign rnd      = total_ff + (total_ff[TOT_W-1] ? ROUND_BIAS : '0);
   assign h_sh     = rnd >>> (2*FRAC_BITS);
   assign sample_h = (is_sample && range_ok) ? h_sh[HW-1:0] : '0;

   // dirty box and change count after this item
   always_comb begin
      min_x_in = min_x_ff;
      min_y_in = min_y_ff;
      max_x_in = max_x_ff;
      max_y_in = max_y_ff;
      count_in = count_ff;
      if (write_ok) begin
         if (count_ff == 16'd0) begin
            min_x_in = ix8;
            max_x_in = ix8;
            min_y_in = iy8;
            max_y_in = iy8;
         end else begin
            if (ix8 < min_x_ff) min_x_in = ix8;
            if (ix8 > max_x_ff) max_x_in = ix8;
            if (iy8 < min_y_ff) min_y_in = iy8;
            if (iy8 > max_y_ff) max_y_in = iy8;
         end
         if (count_ff != 16'hFFFF) begin
            count_in = count_ff + 16'd1;
         end
      end else if (is_clear) begin
         min_x_in = '0;
         min_y_in = '0;
         max_x_in = '0;
         max_y_in = '0;
         count_in = '0;
      end
   end

   assign csr_val = (csr_wdata > hgbs_pkg::MAP_DIM_MAX) ? hgbs_pkg::MAP_DIM_MAX : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= hgbs_pkg::MAP_DIM_RESET;
         height_ff  <= hgbs_pkg::MAP_DIM_RESET;
         clr_cnt_ff <= '0;
         min_x_ff   <= '0;
         min_y_ff   <= '0;
         max_x_ff   <= '0;
         max_y_ff   <= '0;
         count_ff   <= '0;
      end else begin
         if (csr_we && csr_index == hgbs_pkg::REG_MAP_WIDTH) begin
            width_ff <= csr_val;
         end
         if (csr_we && csr_index == hgbs_pkg::REG_MAP_HEIGHT) begin
            height_ff <= csr_val;
         end
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
         if (cmd.finish) begin
            min_x_ff <= min_x_in;
            min_y_ff <= min_y_in;
            max_x_ff <= max_x_in;
            max_y_ff <= max_y_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.calc_index) begin
         base_ff     <= base_in;
         coord_ok_ff <= coord_ok_in;
      end
      row_ff   <= row_in;
      total_ff <= total_in;
      if (cmd.finish) begin
         rsp_ff.sample_height <= sample_h;
         rsp_ff.out_of_range  <= (is_write || is_sample) && !range_ok;
         rsp_ff.dirty_min_x   <= min_x_in;
         rsp_ff.dirty_min_y   <= min_y_in;
         rsp_ff.dirty_max_x   <= max_x_in;
         rsp_ff.dirty_max_y   <= max_y_in;
         rsp_ff.change_count  <= count_in;
      end
   end

   assign rsp_payload    = rsp_ff;
   assign sts.clear_last = (clr_cnt_ff == ADDR_W'(CELLS - 1));
   assign sts.is_sample  = is_sample;

endmodule

`default_nettype wire

FILE: hw/rtl/hgbs_controller.sv
// sequencer for the height grid sampler: clearing sweep, item handshake, read and blend steps
// depends on hgbs_pkg and height_grid_bilinear_sampler_macros.svh
`default_nettype none
`include "height_grid_bilinear_sampler_macros.svh"

module hgbs_controller (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output hgbs_pkg::dp_cmd_type      cmd,
   input  wire hgbs_pkg::dp_sts_type sts
);

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b0000000001,
      ST_IDLE  = 10'b0000000010,
      ST_INDEX = 10'b0000000100,
      ST_RD0   = 10'b0000001000,
      ST_RD1   = 10'b0000010000,
      ST_RD2   = 10'b0000100000,
      ST_RD3   = 10'b0001000000,
      ST_ROW   = 10'b0010000000,
      ST_SUM   = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.rd_sel = hgbs_pkg::SEL_P0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_INDEX;
            end
         end
         ST_INDEX: begin
            cmd.calc_index = 1'b1;
            state_in = sts.is_sample ? ST_RD0 : ST_DONE;
         end
         ST_RD0: begin
            state_in = ST_RD1;
         end
         ST_RD1: begin
            cmd.rd_sel    = hgbs_pkg::SEL_P1;
            cmd.mac_first = 1'b1;
            state_in      = ST_RD2;
         end
         ST_RD2: begin
            cmd.rd_sel     = hgbs_pkg::SEL_P2;
            cmd.mac_second = 1'b1;
            state_in       = ST_RD3;
         end
         ST_RD3: begin
            // top row goes to the second multiplier while the bottom row starts
            cmd.rd_sel    = hgbs_pkg::SEL_P3;
            cmd.mac_first = 1'b1;
            cmd.sum_first = 1'b1;
            state_in      = ST_ROW;
         end
         ST_ROW: begin
            cmd.mac_second = 1'b1;
            state_in       = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_second = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `HGBS_ASSERT_NEXT(a_accept_to_index, clock, reset, req_valid && !req_stall, state_ff == ST_INDEX, "accepted item did not move to index step")
   `HGBS_ASSERT_NOW(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE), "result appeared outside the finish step")
   `HGBS_ASSERT_NEXT(a_done_holds, clock, reset, state_ff == ST_DONE && rsp_valid_ff && rsp_stall, state_ff == ST_DONE && rsp_valid_ff, "finish step overran a held result")
   `HGBS_ASSERT_NEXT(a_sweep_continues, clock, reset, state_ff == ST_CLEAR && !sts.clear_last, state_ff == ST_CLEAR, "clearing sweep left early")

endmodule

`default_nettype wire

FILE: hw/rtl/height_grid_bilinear_sampler.sv
// top level of the height grid bilinear sampler: controller plus datapath
// depends on hgbs_pkg, hgbs_controller and hgbs_datapath
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------------
//  req     | in  | req_valid/req_stall  | req_payload (operation, x, y, height)
//  rsp     | out | rsp_valid/rsp_stall  | rsp_payload (height, flag, box, count)
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_wdata (always ready)
//
// sample: accept, then the index step, four reads of the single-port grid memory and
//   the two-multiplier blend chain, then finish; the next item is accepted only after finish
// write, clear and unused codes: accept, index and finish steps only
// after reset the grid memory is zeroed one cell per cycle, all MAX_SIDE*MAX_SIDE
//   cells (65536 at default), with req_stall high throughout
// a finished item waits in the result register; the next item is worked on meanwhile
`default_nettype none

module height_grid_bilinear_sampler #(
   parameter int MAX_SIDE  = 256,
   parameter int FRAC_BITS = 8
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire hgbs_pkg::req_type         req_payload,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output hgbs_pkg::rsp_type              rsp_payload,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [hgbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [7:0]                      csr_wdata
);

   hgbs_pkg::dp_cmd_type cmd;
   hgbs_pkg::dp_sts_type sts;
   logic                 csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   hgbs_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   hgbs_datapath #(
      .MAX_SIDE  (MAX_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// self-checking bench for height_grid_bilinear_sampler: directed table and random phases
// depends on hgbs_pkg and the sampler rtl; keeps its own copy of the grid, dirty box and count
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES     = 7;
   localparam int SETTLE_CYCLES    = 12;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int FRAC             = 8;
   localparam longint ONE          = longint'(1) << FRAC;
   localparam int GRID_CELLS       = 256 * 256;
   localparam int PHASES           = 7;
   localparam int RANDOM_PER_PHASE = 275;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   hgbs_pkg::req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   hgbs_pkg::rsp_type rsp_payload;
   logic    csr_valid;
   logic    csr_ready;
   logic [hgbs_pkg::CSR_IDX_W-1:0] csr_index;
   logic [7:0] csr_wdata;

   height_grid_bilinear_sampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // predicted grid state
   logic signed [15:0] grid_cells [0:GRID_CELLS-1];
   logic [7:0]  box_min_x, box_min_y, box_max_x, box_max_y;
   logic [15:0] writes_since_clear;
   int          map_cols, map_rows;

   hgbs_pkg::rsp_type height_results_due [$];
   int      fail_count = 0;
   int      burst_left = 0;

   logic [7:0] phase_w [PHASES] = '{8'd62, 8'd0, 8'd254, 8'd255, 8'd3, 8'd130, 8'd17};
   logic [7:0] phase_h [PHASES] = '{8'd62, 8'd0, 8'd254, 8'd3, 8'd255, 8'd1, 8'd9};

   typedef struct {
      hgbs_pkg::req_type item;
      bit                typed;
      hgbs_pkg::rsp_type want;
   } table_row_type;

   table_row_type directed_rows [$];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit cell_inside(input int x, input int y);
      return x < map_cols && y < map_rows && (x + y * map_cols) < GRID_CELLS;
   endfunction

   function automatic longint cell_at(input int x, input int y);
      return longint'(grid_cells[x + y * map_cols]);
   endfunction

   function automatic hgbs_pkg::rsp_type apply_grid_op(input hgbs_pkg::req_type r);
      hgbs_pkg::rsp_type res;
      int      ix, iy;
      logic [7:0] cx, cy;
      longint  dx, dy, top, bot, blend;
      res = '0;
      ix = int'(r.x_coord[15:8]);
      iy = int'(r.y_coord[15:8]);
      cx = r.x_coord[15:8];
      cy = r.y_coord[15:8];
      case (r.operation)
         hgbs_pkg::OP_WRITE: begin
            if (cell_inside(ix, iy)) begin
               grid_cells[ix + iy * map_cols] = r.write_height;
               if (writes_since_clear == 16'd0) begin
                  box_min_x = cx;
                  box_max_x = cx;
                  box_min_y = cy;
                  box_max_y = cy;
               end else begin
                  if (cx < box_min_x) box_min_x = cx;
                  if (cx > box_max_x) box_max_x = cx;
                  if (cy < box_min_y) box_min_y = cy;
                  if (cy > box_max_y) box_max_y = cy;
               end
               if (writes_since_clear != 16'hFFFF) writes_since_clear++;
            end else begin
               res.out_of_range = 1'b1;
            end
         end
         hgbs_pkg::OP_SAMPLE: begin
            // far corner has the largest index, so it covers the other three
            if (cell_inside(ix + 1, iy + 1)) begin
               dx = longint'(r.x_coord[FRAC-1:0]);
               dy = longint'(r.y_coord[FRAC-1:0]);
               top = cell_at(ix, iy) * (ONE - dx) + cell_at(ix + 1, iy) * dx;
               bot = cell_at(ix, iy + 1) * (ONE - dx) + cell_at(ix + 1, iy + 1) * dx;
               // signed division truncates toward zero
               blend = (top * (ONE - dy) + bot * dy) / (ONE * ONE);
               res.sample_height = blend[15:0];
            end else begin
               res.out_of_range = 1'b1;
            end
         end
         hgbs_pkg::OP_CLEAR: begin
            writes_since_clear = '0;
            box_min_x = '0;
            box_min_y = '0;
            box_max_x = '0;
            box_max_y = '0;
         end
         default: ;
      endcase
      res.dirty_min_x  = box_min_x;
      res.dirty_min_y  = box_min_y;
      res.dirty_max_x  = box_max_x;
      res.dirty_max_y  = box_max_y;
      res.change_count = writes_since_clear;
      return res;
   endfunction

   function automatic hgbs_pkg::rsp_type rsp_of(input logic [15:0] h, input bit oor,
                                                input logic [7:0] x0, input logic [7:0] y0,
                                                input logic [7:0] x1, input logic [7:0] y1,
                                                input logic [15:0] cnt);
      hgbs_pkg::rsp_type res;
      res.sample_height = h;
      res.out_of_range  = oor;
      res.dirty_min_x   = x0;
      res.dirty_min_y   = y0;
      res.dirty_max_x   = x1;
      res.dirty_max_y   = y1;
      res.change_count  = cnt;
      return res;
   endfunction

   task automatic add_row(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y,
                          input logic [15:0] h, input bit typed = 1'b0,
                          input hgbs_pkg::rsp_type want = '0);
      table_row_type row;
      row.item.operation    = op;
      row.item.x_coord      = x;
      row.item.y_coord      = y;
      row.item.write_height = h;
      row.typed             = typed;
      row.want              = want;
      directed_rows = {directed_rows, row};
   endtask

   function automatic logic [15:0] rand_height();
      case ($urandom_range(7, 0))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] rand_frac();
      case ($urandom_range(7, 0))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // bias toward both ends of the range so writes and samples overlap
   function automatic int pick_index(input int hi);
      case ($urandom_range(2, 0))
         0: return $urandom_range(hi, 0);
         1: return $urandom_range((hi < 3) ? hi : 3, 0);
         default: return $urandom_range(hi, (hi < 3) ? 0 : hi - 3);
      endcase
   endfunction

   function automatic hgbs_pkg::req_type random_item();
      hgbs_pkg::req_type r;
      int      kind, ix, iy;
      r.operation    = $urandom_range(1, 0) ? hgbs_pkg::OP_WRITE : hgbs_pkg::OP_SAMPLE;
      r.x_coord      = 16'($urandom);
      r.y_coord      = 16'($urandom);
      r.write_height = rand_height();
      kind = $urandom_range(99, 0);
      if (kind < 40) begin
         r.operation = hgbs_pkg::OP_SAMPLE;
         r.x_coord   = {8'(pick_index(map_cols - 2)), rand_frac()};
         r.y_coord   = {8'(pick_index(map_rows - 2)), rand_frac()};
      end else if (kind < 70) begin
         r.operation = hgbs_pkg::OP_WRITE;
         r.x_coord   = {8'(pick_index(map_cols - 1)), rand_frac()};
         r.y_coord   = {8'(pick_index(map_rows - 1)), rand_frac()};
      end else if (kind < 75) begin
         r.operation = hgbs_pkg::OP_CLEAR;
      end else if (kind < 80) begin
         r.operation = OP_UNUSED;
      end else if (kind < 90) begin
         // just past the edge of the grid on one axis
         ix = pick_index(map_cols - 2);
         iy = pick_index(map_rows - 2);
         if ($urandom_range(1, 0))
            ix = map_cols - 1 + int'(r.operation == hgbs_pkg::OP_WRITE);
         else
            iy = map_rows - 1 + int'(r.operation == hgbs_pkg::OP_WRITE);
         if (ix <= 255 && iy <= 255) begin
            r.x_coord = {8'(ix), rand_frac()};
            r.y_coord = {8'(iy), rand_frac()};
         end
      end
      return r;
   endfunction

   task automatic send_item(input hgbs_pkg::req_type item, input bit typed,
                            input hgbs_pkg::rsp_type typed_want);
      hgbs_pkg::rsp_type predicted;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(10, 1);
         req_valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = apply_grid_op(item);
      height_results_due = {height_results_due, (typed ? typed_want : predicted)};
      burst_left--;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (height_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_map_dims(input logic [7:0] w_val, input logic [7:0] h_val);
      csr_valid <= 1'b1;
      csr_index <= hgbs_pkg::REG_MAP_WIDTH;
      csr_wdata <= w_val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_index <= hgbs_pkg::REG_MAP_HEIGHT;
      csr_wdata <= h_val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      map_cols = int'((w_val > hgbs_pkg::MAP_DIM_MAX) ? hgbs_pkg::MAP_DIM_MAX : w_val) + 2;
      map_rows = int'((h_val > hgbs_pkg::MAP_DIM_MAX) ? hgbs_pkg::MAP_DIM_MAX : h_val) + 2;
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
         fail_count++;
      end
   endtask

   initial begin : result_check
      hgbs_pkg::rsp_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (height_results_due.size() == 0) begin
               $display("%0t: unexpected item, expected none, got %h", $time, rsp_payload);
               fail_count++;
            end else begin
               want = height_results_due.pop_front();
               check_field("sample_height", want.sample_height, rsp_payload.sample_height);
               check_field("out_of_range", 16'(want.out_of_range),
                           16'(rsp_payload.out_of_range));
               check_field("dirty_min_x", 16'(want.dirty_min_x), 16'(rsp_payload.dirty_min_x));
               check_field("dirty_min_y", 16'(want.dirty_min_y), 16'(rsp_payload.dirty_min_y));
               check_field("dirty_max_x", 16'(want.dirty_max_x), 16'(rsp_payload.dirty_max_x));
               check_field("dirty_max_y", 16'(want.dirty_max_y), 16'(rsp_payload.dirty_max_y));
               check_field("change_count", want.change_count, rsp_payload.change_count);
            end
         end
      end
   end

   // result side back-pressure: random segments, plus one long hold-off
   initial begin : rsp_stall_pattern
      int seen;
      int seg_left;
      int stall_pct;
      bit held;
      seen      = 0;
      seg_left  = 0;
      stall_pct = 0;
      held      = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) seen++;
         if (!held && seen >= 150) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(60, 4);
               case ($urandom_range(2, 0))
                  0: stall_pct = 0;
                  1: stall_pct = 30;
                  default: stall_pct = 80;
               endcase
            end
            seg_left--;
            rsp_stall <= ($urandom_range(99, 0) < stall_pct);
         end
      end
   end

   initial begin : stimulus
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      reset       <= 1'b1;
      foreach (grid_cells[i]) grid_cells[i] = '0;
      box_min_x = '0;
      box_min_y = '0;
      box_max_x = '0;
      box_max_y = '0;
      writes_since_clear = '0;
      map_cols = int'(hgbs_pkg::MAP_DIM_RESET) + 2;
      map_rows = int'(hgbs_pkg::MAP_DIM_RESET) + 2;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset size of 64 by 64 stored cells
      add_row(hgbs_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b1,
              rsp_of(0, 0, 0, 0, 0, 0, 0));
      add_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0));
      // first write after clear sets the box to that cell
      add_row(hgbs_pkg::OP_WRITE, 16'h3F00, 16'h3EFF, 16'h7FFF, 1'b1,
              rsp_of(0, 0, 63, 62, 63, 62, 1));
      add_row(hgbs_pkg::OP_WRITE, 16'h4000, 16'h0000, 16'h1234, 1'b1,
              rsp_of(0, 1, 63, 62, 63, 62, 1));
      add_row(hgbs_pkg::OP_WRITE, 16'h0000, 16'h40FF, 16'h5678, 1'b1,
              rsp_of(0, 1, 63, 62, 63, 62, 1));
      // right neighbor off the grid even with zero fraction
      add_row(hgbs_pkg::OP_SAMPLE, 16'h3F00, 16'h0000, 16'h0000, 1'b1,
              rsp_of(0, 1, 63, 62, 63, 62, 1));
      add_row(hgbs_pkg::OP_SAMPLE, 16'h3E00, 16'h3F00, 16'h0000, 1'b1,
              rsp_of(0, 1, 63, 62, 63, 62, 1));
      add_row(hgbs_pkg::OP_WRITE, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b1,
              rsp_of(0, 1, 63, 62, 63, 62, 1));
      add_row(hgbs_pkg::OP_CLEAR, 16'h1234, 16'h5678, 16'h9ABC, 1'b1,
              rsp_of(0, 0, 0, 0, 0, 0, 0));
      add_row(hgbs_pkg::OP_WRITE, 16'h0000, 16'h0000, 16'h7FFF, 1'b1,
              rsp_of(0, 0, 0, 0, 0, 0, 1));
      add_row(hgbs_pkg::OP_WRITE, 16'h0100, 16'h0000, 16'h8000);
      add_row(hgbs_pkg::OP_WRITE, 16'h0000, 16'h0100, 16'h8000);
      add_row(hgbs_pkg::OP_WRITE, 16'h01AB, 16'h01CD, 16'h7FFF);
      add_row(hgbs_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
      add_row(hgbs_pkg::OP_SAMPLE, 16'h00FF, 16'h00FF, 16'h0000);
      // blend just below zero truncates toward zero
      add_row(hgbs_pkg::OP_SAMPLE, 16'h0080, 16'h0080, 16'h0000);
      add_row(hgbs_pkg::OP_SAMPLE, 16'h00FF, 16'h0000, 16'hFFFF);
      add_row(hgbs_pkg::OP_WRITE, 16'h3F00, 16'h3F00, 16'h0001);
      add_row(hgbs_pkg::OP_SAMPLE, 16'h3EFF, 16'h3EFF, 16'h0000);
      add_row(hgbs_pkg::OP_SAMPLE, 16'h3E00, 16'h3E00, 16'h0000);
      add_row(OP_UNUSED, 16'h0000, 16'h0000, 16'h0000);
      add_row(hgbs_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b1,
              rsp_of(0, 0, 0, 0, 0, 0, 0));
      add_row(hgbs_pkg::OP_SAMPLE, 16'h0180, 16'h0040, 16'h0000);
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      // random phases over several grid sizes, oversized register values among them
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0) begin
            wait_idle();
            set_map_dims(phase_w[ph], phase_h[ph]);
         end
         repeat (RANDOM_PER_PHASE) send_item(random_item(), 1'b0, '0);
      end

      wait_idle();
      if (fail_count == 0 && height_results_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
